[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AST_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/ome_pkg.sv]
package ome_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int KEY_W_DEF = 32;
    localparam int AMT_W     = 31;
    localparam int NUM_W     = 32;

    // Request codes
    localparam logic [3:0] REQ_INSERT = 4'd0;
    localparam logic [3:0] REQ_ERASE  = 4'd1;
    localparam logic [3:0] REQ_COUNT  = 4'd2;
    localparam logic [3:0] REQ_RANK   = 4'd3;
    localparam logic [3:0] REQ_KTH    = 4'd4;
    localparam logic [3:0] REQ_PRED   = 4'd5;
    localparam logic [3:0] REQ_SUCC   = 4'd6;
    localparam logic [3:0] REQ_SIZE   = 4'd7;
    localparam logic [3:0] REQ_CLEAR  = 4'd8;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_DECIDE,
        S_SH_RD,
        S_SH_WR,
        S_WRITE,
        S_DONE
    } state_t;

    // Table update chosen after the scan
    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_INS,
        OP_DEL
    } op_t;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic scan_ev;
        logic decide;
        logic sh_rd;
        logic sh_wr;
        logic wr_fin;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_end;
        logic shift_end;
        op_t  op;
    } stat_t;

endpackage

[hdl/ordered_multiset_engine.sv]
// Channel   | Handshake     | Fields
// ----------+---------------+---------------------------------------------------
// request   | start / busy  | req_type, key, amount, rank_index
// result    | done (strobe) | found, result_key, result_number, is_empty, status
//
// Every request scans the used entries through the registered read of the key
// and count memories, then takes a decide step. A count update rewrites the
// entry in place; a new key shifts the entries from its position up and is
// then written; erasing a whole entry shifts the later entries down over it.
// Done rises in the same cycle as busy falls. Reset clears the entry count
// and total; the memories need no clearing. The receiver cannot stall.
module ordered_multiset_engine import ome_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEF,
    parameter int KEY_WIDTH   = KEY_W_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [3:0]                  req_type,
    input  logic signed [KEY_WIDTH-1:0] key,
    input  logic [AMT_W-1:0]            amount,
    input  logic [AMT_W-1:0]            rank_index,
    output logic                        done,
    output logic                        found,
    output logic signed [KEY_WIDTH-1:0] result_key,
    output logic [NUM_W-1:0]            result_number,
    output logic                        is_empty,
    output logic [1:0]                  status
);

    cmd_t  cmd;
    stat_t stat;

    ome_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
    );

    ome_dp #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .req_type(req_type), .key(key), .amount(amount), .rank_index(rank_index),
        .done(done), .found(found), .result_key(result_key),
        .result_number(result_number), .is_empty(is_empty), .status(status)
    );

endmodule

[hdl/ome_ram.sv]
module ome_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/ome_ctrl.sv]
module ome_ctrl import ome_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (start) state_next = S_SCAN_RD;
            S_SCAN_RD: state_next = stat.scan_end ? S_DECIDE : S_SCAN_EV;
            S_SCAN_EV: state_next = S_SCAN_RD;
            S_DECIDE:
            begin
                unique case (stat.op)
                    OP_WRITE: state_next = S_WRITE;
                    OP_INS,
                    OP_DEL:   state_next = S_SH_RD;
                    default:  state_next = S_DONE;
                endcase
            end
            S_SH_RD:
            begin
                if (stat.shift_end)
                begin
                    state_next = (stat.op == OP_INS) ? S_WRITE : S_DONE;
                end
                else
                begin
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:   state_next = S_SH_RD;
            S_WRITE:   state_next = S_DONE;
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd         = '0;
        cmd.load    = (state_reg == S_IDLE) && start;
        cmd.scan_rd = (state_reg == S_SCAN_RD) && !stat.scan_end;
        cmd.scan_ev = (state_reg == S_SCAN_EV);
        cmd.decide  = (state_reg == S_DECIDE);
        cmd.sh_rd   = (state_reg == S_SH_RD) && !stat.shift_end;
        cmd.sh_wr   = (state_reg == S_SH_WR);
        cmd.wr_fin  = (state_reg == S_WRITE);
        cmd.finish  = (state_reg == S_DONE);
        busy        = (state_reg != S_IDLE);
    end

endmodule

[hdl/ome_dp.sv]
module ome_dp import ome_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEF,
    parameter int KEY_WIDTH   = KEY_W_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cmd_t                        cmd,
    output stat_t                       stat,
    input  logic [3:0]                  req_type,
    input  logic signed [KEY_WIDTH-1:0] key,
    input  logic [AMT_W-1:0]            amount,
    input  logic [AMT_W-1:0]            rank_index,
    output logic                        done,
    output logic                        found,
    output logic signed [KEY_WIDTH-1:0] result_key,
    output logic [NUM_W-1:0]            result_number,
    output logic                        is_empty,
    output logic [1:0]                  status
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    // Control state
    logic [CNT_W-1:0] used_reg, used_next;
    logic [AMT_W-1:0] total_reg, total_next;
    logic             done_reg;

    // Request and scan results
    logic [3:0]                  req_reg;
    logic signed [KEY_WIDTH-1:0] key_reg;
    logic [AMT_W-1:0]            amt_reg, kidx_reg, hitcnt_reg;
    logic [CNT_W-1:0]            idx_reg, pos_reg;
    logic [NUM_W-1:0]            below_reg, acc_reg;
    logic                        pos_done_reg, hit_reg, want_succ_reg;
    logic                        pred_f_reg, succ_f_reg, kth_f_reg;
    logic signed [KEY_WIDTH-1:0] pred_key_reg, succ_key_reg, kth_key_reg;

    // Output registers
    logic                        found_reg, empty_reg;
    logic signed [KEY_WIDTH-1:0] rkey_reg;
    logic [NUM_W-1:0]            rnum_reg;
    logic [1:0]                  status_reg;

    // Table memories
    logic                        we;
    logic [IDX_W-1:0]            waddr, raddr;
    logic signed [KEY_WIDTH-1:0] wkey, rd_key;
    logic [AMT_W-1:0]            wcnt, rd_cnt;
    logic [CNT_W-1:0]            raddr_full;

    ome_ram #(.WIDTH(KEY_WIDTH), .DEPTH(TABLE_DEPTH)) u_keys (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wkey), .raddr(raddr), .rdata(rd_key)
    );

    ome_ram #(.WIDTH(AMT_W), .DEPTH(TABLE_DEPTH)) u_cnts (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wcnt), .raddr(raddr), .rdata(rd_cnt)
    );

    // Derived decisions
    logic [NUM_W-1:0] ins_sum;
    logic             ovf, amt_nz;
    logic [NUM_W-1:0] acc_sum;
    op_t              op;

    assign amt_nz  = (amt_reg != '0);
    assign ins_sum = {1'b0, total_reg} + {1'b0, amt_reg};
    assign ovf     = ins_sum[NUM_W-1];
    assign acc_sum = acc_reg + {1'b0, rd_cnt};

    always_comb
    begin
        op = OP_NONE;
        if (req_reg == REQ_INSERT && amt_nz && !ovf)
        begin
            if (hit_reg)
            begin
                op = OP_WRITE;
            end
            else if (used_reg < CNT_FULL)
            begin
                op = OP_INS;
            end
        end
        else if (req_reg == REQ_ERASE && amt_nz && hit_reg)
        begin
            op = (hitcnt_reg > amt_reg) ? OP_WRITE : OP_DEL;
        end
    end

    assign stat.op        = op;
    assign stat.scan_end  = (idx_reg == used_reg);
    assign stat.shift_end = (op == OP_INS) ? (idx_reg == pos_reg)
                                           : ((idx_reg + CNT_ONE) == used_reg);

    // Memory ports
    always_comb
    begin
        raddr_full = idx_reg;
        if (cmd.sh_rd)
        begin
            raddr_full = (op == OP_INS) ? (idx_reg - CNT_ONE) : (idx_reg + CNT_ONE);
        end
    end

    assign raddr = raddr_full[IDX_W-1:0];
    assign we    = cmd.sh_wr | cmd.wr_fin;
    assign waddr = cmd.wr_fin ? pos_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign wkey  = cmd.sh_wr ? rd_key : key_reg;

    // Count written back: moved entry, reduced count, grown count or new count
    always_comb
    begin
        wcnt = amt_reg;
        if (cmd.sh_wr)
        begin
            wcnt = rd_cnt;
        end
        else if (req_reg == REQ_ERASE)
        begin
            wcnt = hitcnt_reg - amt_reg;
        end
        else if (hit_reg)
        begin
            wcnt = hitcnt_reg + amt_reg;
        end
    end

    // Result and commit values
    logic             res_found;
    logic signed [KEY_WIDTH-1:0] res_key;
    logic [NUM_W-1:0] res_num;
    logic [1:0]       res_status;

    always_comb
    begin
        used_next  = used_reg;
        total_next = total_reg;
        res_found  = 1'b0;
        res_key    = '0;
        res_status = ST_OK;
        unique case (req_reg)
            REQ_INSERT:
            begin
                if (amt_nz && ovf)
                begin
                    res_status = ST_OVF;
                end
                else if (amt_nz && op == OP_NONE)
                begin
                    res_status = ST_FULL;
                end
                if (op != OP_NONE)
                begin
                    total_next = ins_sum[AMT_W-1:0];
                end
                if (op == OP_INS)
                begin
                    used_next = used_reg + CNT_ONE;
                end
            end
            REQ_ERASE:
            begin
                res_found = amt_nz && hit_reg;
                if (op == OP_WRITE)
                begin
                    total_next = total_reg - amt_reg;
                end
                else if (op == OP_DEL)
                begin
                    total_next = total_reg - hitcnt_reg;
                    used_next  = used_reg - CNT_ONE;
                end
            end
            REQ_KTH:
            begin
                res_found = kth_f_reg;
                res_key   = kth_f_reg ? kth_key_reg : '0;
            end
            REQ_PRED:
            begin
                res_found = pred_f_reg;
                res_key   = pred_f_reg ? pred_key_reg : '0;
            end
            REQ_SUCC:
            begin
                res_found = succ_f_reg;
                res_key   = succ_f_reg ? succ_key_reg : '0;
            end
            REQ_CLEAR:
            begin
                used_next  = '0;
                total_next = '0;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        priority case (req_reg)
            REQ_COUNT: res_num = hit_reg ? {1'b0, hitcnt_reg} : '0;
            REQ_RANK:  res_num = below_reg + NUM_W'(1);
            REQ_KTH,
            REQ_PRED,
            REQ_SUCC:  res_num = '0;
            default:   res_num = {1'b0, total_next};
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                used_reg  <= used_next;
                total_reg <= total_next;
            end
        end
    end

    // Request capture, scan, shift pointer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg       <= req_type;
            key_reg       <= key;
            amt_reg       <= amount;
            kidx_reg      <= rank_index;
            idx_reg       <= '0;
            pos_reg       <= used_reg;
            below_reg     <= '0;
            acc_reg       <= '0;
            pos_done_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            hitcnt_reg    <= '0;
            want_succ_reg <= 1'b0;
            pred_f_reg    <= 1'b0;
            succ_f_reg    <= 1'b0;
            kth_f_reg     <= 1'b0;
            pred_key_reg  <= '0;
            succ_key_reg  <= '0;
            kth_key_reg   <= '0;
        end
        // Evaluate one table entry
        if (cmd.scan_ev)
        begin
            idx_reg <= idx_reg + CNT_ONE;
            acc_reg <= acc_sum;
            if (!kth_f_reg && kidx_reg != '0 && {1'b0, kidx_reg} <= acc_sum)
            begin
                kth_f_reg   <= 1'b1;
                kth_key_reg <= rd_key;
            end
            if (!pos_done_reg)
            begin
                if (rd_key < key_reg)
                begin
                    below_reg    <= below_reg + {1'b0, rd_cnt};
                    pred_f_reg   <= 1'b1;
                    pred_key_reg <= rd_key;
                end
                else
                begin
                    pos_done_reg <= 1'b1;
                    pos_reg      <= idx_reg;
                    hit_reg      <= (rd_key == key_reg);
                    hitcnt_reg   <= rd_cnt;
                    if (rd_key == key_reg)
                    begin
                        want_succ_reg <= 1'b1;
                    end
                    else
                    begin
                        succ_f_reg   <= 1'b1;
                        succ_key_reg <= rd_key;
                    end
                end
            end
            else if (want_succ_reg)
            begin
                want_succ_reg <= 1'b0;
                succ_f_reg    <= 1'b1;
                succ_key_reg  <= rd_key;
            end
        end
        // Shift pointer: insert walks down from the end, erase walks up
        if (cmd.decide)
        begin
            idx_reg <= (op == OP_INS) ? used_reg : pos_reg;
        end
        if (cmd.sh_wr)
        begin
            idx_reg <= (op == OP_INS) ? (idx_reg - CNT_ONE) : (idx_reg + CNT_ONE);
        end
        // Result beat
        if (cmd.finish)
        begin
            found_reg  <= res_found;
            rkey_reg   <= res_key;
            rnum_reg   <= res_num;
            empty_reg  <= (total_next == '0);
            status_reg <= res_status;
        end
    end

    assign done          = done_reg;
    assign found         = found_reg;
    assign result_key    = rkey_reg;
    assign result_number = rnum_reg;
    assign is_empty      = empty_reg;
    assign status        = status_reg;

endmodule

[hdl/ome_checker.sv]
`include "assert_macros.svh"

module ome_checker import ome_pkg::*; #(
    parameter int KEY_WIDTH = KEY_W_DEF
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic                 found,
    input logic [KEY_WIDTH-1:0] result_key,
    input logic [1:0]           status
);

    // A taken request holds the engine busy
    `AST_NEXT(a_accept_busy, start && !busy, busy)
    // The result beat comes as the engine returns to idle
    `AST_IMPLY(a_done_idle, done, !busy)
    // Busy only rises after a request
    `AST_IMPLY(a_busy_cause, $rose(busy), $past(start))
    // No key is reported without a hit
    `AST_IMPLY(a_key_found, done && !found, result_key == '0)
    // Refusals never come with a hit
    `AST_IMPLY(a_status_found, done && status != ST_OK, !found)

endmodule

bind ordered_multiset_engine ome_checker #(.KEY_WIDTH(KEY_WIDTH)) u_ome_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .found(found), .result_key(result_key), .status(status)
);

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import ome_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    typedef struct {
        logic              found;
        logic signed [31:0] rkey;
        logic [31:0]       rnum;
        logic              empty;
        logic [1:0]        st;
    } ms_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         req_type;
    logic signed [31:0] key;
    logic [30:0]        amount;
    logic [30:0]        rank_index;
    logic               done;
    logic               found;
    logic signed [31:0] result_key;
    logic [31:0]        result_number;
    logic               is_empty;
    logic [1:0]         status;

    // shadow copy of the multiset
    logic signed [31:0] shadow_keys[DEPTH];
    logic [30:0]        shadow_counts[DEPTH];
    int                 shadow_used;
    logic [30:0]        shadow_total;

    ms_result_t pending_results[$];
    int         error_count;

    ordered_multiset_engine u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .key(key), .amount(amount), .rank_index(rank_index),
        .done(done), .found(found), .result_key(result_key),
        .result_number(result_number), .is_empty(is_empty), .status(status)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // expected result of one request, updating the shadow set
    function automatic ms_result_t predict_multiset(logic [3:0] rq, logic signed [31:0] k,
                                                    logic [30:0] amt, logic [30:0] kidx);
        ms_result_t r;
        int         pos;
        int         j;
        bit         hit;
        logic [32:0] acc;
        r = '{found: 1'b0, rkey: '0, rnum: '0, empty: 1'b0, st: ST_OK};
        pos = 0;
        while (pos < shadow_used && shadow_keys[pos] < k)
            pos++;
        hit = pos < shadow_used && shadow_keys[pos] == k;
        case (rq)
            REQ_INSERT:
            begin
                if (amt != 0)
                begin
                    if ({2'b0, shadow_total} + {2'b0, amt} > 33'h7FFFFFFF)
                        r.st = ST_OVF;
                    else if (hit)
                    begin
                        shadow_counts[pos] += amt;
                        shadow_total += amt;
                    end
                    else if (shadow_used >= DEPTH)
                        r.st = ST_FULL;
                    else
                    begin
                        for (j = shadow_used; j > pos; j--)
                        begin
                            shadow_keys[j] = shadow_keys[j-1];
                            shadow_counts[j] = shadow_counts[j-1];
                        end
                        shadow_keys[pos] = k;
                        shadow_counts[pos] = amt;
                        shadow_used++;
                        shadow_total += amt;
                    end
                end
                r.rnum = {1'b0, shadow_total};
            end
            REQ_ERASE:
            begin
                if (amt != 0 && hit)
                begin
                    r.found = 1'b1;
                    if (shadow_counts[pos] > amt)
                    begin
                        shadow_counts[pos] -= amt;
                        shadow_total -= amt;
                    end
                    else
                    begin
                        shadow_total -= shadow_counts[pos];
                        for (j = pos; j + 1 < shadow_used; j++)
                        begin
                            shadow_keys[j] = shadow_keys[j+1];
                            shadow_counts[j] = shadow_counts[j+1];
                        end
                        shadow_used--;
                    end
                end
                r.rnum = {1'b0, shadow_total};
            end
            REQ_COUNT:
                r.rnum = hit ? {1'b0, shadow_counts[pos]} : 32'd0;
            REQ_RANK:
            begin
                r.rnum = 32'd1;
                for (j = 0; j < pos; j++)
                    r.rnum += {1'b0, shadow_counts[j]};
            end
            REQ_KTH:
            begin
                if (kidx != 0 && kidx <= shadow_total)
                begin
                    acc = '0;
                    for (j = 0; j < shadow_used; j++)
                    begin
                        acc += {2'b0, shadow_counts[j]};
                        if ({2'b0, kidx} <= acc)
                        begin
                            r.found = 1'b1;
                            r.rkey = shadow_keys[j];
                            break;
                        end
                    end
                end
            end
            REQ_PRED:
            begin
                if (pos > 0)
                begin
                    r.found = 1'b1;
                    r.rkey = shadow_keys[pos-1];
                end
            end
            REQ_SUCC:
            begin
                j = hit ? pos + 1 : pos;
                if (j < shadow_used)
                begin
                    r.found = 1'b1;
                    r.rkey = shadow_keys[j];
                end
            end
            REQ_CLEAR:
            begin
                shadow_used = 0;
                shadow_total = '0;
            end
            default:
                r.rnum = {1'b0, shadow_total};
        endcase
        r.empty = shadow_total == 0;
        return r;
    endfunction

    // send one request beat
    task automatic send_request(logic [3:0] rq, logic signed [31:0] k,
                                logic [30:0] amt, logic [30:0] kidx);
        int         gap;
        ms_result_t expected;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
              ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 2));
        // random gap after the previous accept, never empty
        repeat (gap + 1) @(posedge clk);
        start      <= 1'b1;
        req_type   <= rq;
        key        <= k;
        amount     <= amt;
        rank_index <= kidx;
        // wait for the edge that takes the beat
        do
        begin
            @(posedge clk);
        end
        while (busy);
        expected = predict_multiset(rq, k, amt, kidx);
        pending_results = {pending_results, expected};
        start <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        ms_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat", $time);
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (found !== e.found || result_key !== e.rkey ||
                    result_number !== e.rnum || is_empty !== e.empty || status !== e.st)
                begin
                    $display({"%0t: expected f=%0b k=%0d n=%0d e=%0b s=%0d,",
                              " got f=%0b k=%0d n=%0d e=%0b s=%0d"},
                             $time, e.found, e.rkey, e.rnum, e.empty, e.st,
                             found, result_key, result_number, is_empty, status);
                    error_count++;
                end
            end
        end
    end

    function automatic logic signed [31:0] pick_key(int span);
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'sh7FFFFFFF - $urandom_range(0, 3);
            2:       return 32'sh80000000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 2 * span)) - span;
        endcase
    endfunction

    function automatic logic [30:0] pick_amount();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 31'($urandom);
            2:       return 31'h7FFFFFFF - 31'($urandom_range(0, 2));
            default: return 31'($urandom_range(1, 5));
        endcase
    endfunction

    task automatic test_directed();
        send_request(REQ_SIZE, 0, 0, 0);
        send_request(REQ_PRED, 0, 0, 0);
        send_request(REQ_SUCC, 0, 0, 0);
        send_request(REQ_KTH, 0, 0, 1);
        send_request(REQ_INSERT, 32'sh80000000, 3, 0);
        send_request(REQ_INSERT, 32'sh7FFFFFFF, 2, 0);
        send_request(REQ_INSERT, 5, 0, 0);
        send_request(REQ_INSERT, 5, 31'h7FFFFFFF, 0);
        send_request(REQ_INSERT, 5, 4, 0);
        send_request(REQ_COUNT, 5, 0, 0);
        send_request(REQ_RANK, 32'sh7FFFFFFF, 0, 0);
        send_request(REQ_KTH, 0, 0, 0);
        send_request(REQ_KTH, 0, 0, 31'h7FFFFFFF);
        send_request(REQ_KTH, 0, 0, 9);
        send_request(REQ_PRED, 5, 0, 0);
        send_request(REQ_SUCC, 5, 0, 0);
        send_request(REQ_ERASE, 6, 1, 0);
        send_request(REQ_ERASE, 5, 0, 0);
        send_request(REQ_ERASE, 5, 1, 0);
        send_request(REQ_ERASE, 5, 31'h7FFFFFFF, 0);
        send_request(4'd9, 0, 0, 0);
        send_request(4'd15, 32'hFFFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
        send_request(REQ_CLEAR, 0, 0, 0);
        send_request(REQ_SIZE, 0, 0, 0);
    endtask

    // fill the table to capacity and probe the full case
    task automatic test_full_table();
        int n;
        for (n = 0; n < DEPTH; n++)
            send_request(REQ_INSERT, $signed(n * 3 - 90), 1, 0);
        send_request(REQ_INSERT, 1000, 1, 0);
        send_request(REQ_INSERT, -90, 2, 0);
        send_request(REQ_KTH, 0, 0, DEPTH);
        send_request(REQ_RANK, 500, 0, 0);
        send_request(REQ_CLEAR, 0, 0, 0);
    endtask

    task automatic test_random(int count);
        int n;
        int span;
        logic [3:0] rq;
        span = 20;
        for (n = 0; n < count; n++)
        begin
            if (n % 200 == 0)
                span = $urandom_range(0, 2) == 0 ? 100 : 20;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: rq = REQ_INSERT;
                6, 7, 8:          rq = REQ_ERASE;
                19:               rq = ($urandom_range(0, 7) == 0) ? REQ_CLEAR :
                                       4'($urandom_range(9, 15));
                default:          rq = 4'($urandom_range(2, 7));
            endcase
            send_request(rq, pick_key(span), pick_amount(),
                         $urandom_range(0, 3) == 0 ? 31'($urandom) :
                         31'($urandom_range(0, shadow_total + 1)));
        end
    endtask

    initial
    begin
        error_count = 0;
        shadow_used = 0;
        shadow_total = '0;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_SIZE;
        key = 0;
        amount = 0;
        rank_index = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_random(1450);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end
endmodule
